// ===== design/kwm_pkg.sv =====
package kwm_pkg;

  localparam int LANES        = 13;
  localparam int MAX_WORD_LEN = 15;
  localparam int LANE_W       = 4;
  localparam int LEN_W        = 4;
  localparam int RAM_DEPTH    = 16;
  localparam int HALF         = (LANES + 1) / 2;

  localparam logic [1:0] FUNC_CHAR  = 2'd0;
  localparam logic [1:0] FUNC_LAST  = 2'd1;
  localparam logic [1:0] FUNC_EXH   = 2'd2;
  localparam logic [1:0] FUNC_UNDEF = 2'd3;

  localparam logic [LANES-1:0] ALL_LANES = {LANES{1'b1}};

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] lane;
    logic [7:0] char_code;
  } in_req_t;

  typedef struct packed {
    logic [3:0] out_lane;
    logic [7:0] out_char;
    logic       word_last;
    logic       all_done;
    logic       error;
  } out_res_t;

  typedef struct packed {
    in_req_t req;
    logic    bad;
  } q_entry_t;

  function automatic logic [LANE_W-1:0] lowest_lane(input logic [LANES-1:0] m);
    logic [LANE_W-1:0] r;
    r = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (m[i]) r = LANE_W'(i);
    end
    return r;
  endfunction

endpackage

// ===== design/kwm_ram.sv =====
module kwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== design/kwm_front.sv =====
module kwm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kwm_pkg::in_req_t  in_data,
  output logic              q_valid,
  output kwm_pkg::q_entry_t q_head,
  input  logic              q_pop
);

  // Two-entry request queue; requests are flagged as malformed on entry.
  kwm_pkg::q_entry_t ent_r [2];
  logic              rd_ptr_r, wr_ptr_r;
  logic [1:0]        cnt_r;
  logic              push;
  kwm_pkg::q_entry_t new_ent;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_head   = ent_r[rd_ptr_r];

  always_comb begin
    new_ent.req = in_data;
    new_ent.bad = (in_data.lane >= 4'(kwm_pkg::LANES))
                  || (in_data.func == kwm_pkg::FUNC_UNDEF);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      if (push && !q_pop) cnt_r <= cnt_r + 2'd1;
      else if (!push && q_pop) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= new_ent;
  end

endmodule

// ===== design/kwm_back.sv =====
module kwm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [3:0]        key_offset,
  input  logic              q_valid,
  input  kwm_pkg::q_entry_t q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output kwm_pkg::out_res_t out_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_MIN   = 3'd3;
  localparam logic [2:0] S_FLT   = 3'd4;
  localparam logic [2:0] S_EMRD  = 3'd5;
  localparam logic [2:0] S_EMWR  = 3'd6;
  localparam logic [2:0] S_STAT  = 3'd7;

  localparam int LN = kwm_pkg::LANES;
  localparam int HF = kwm_pkg::HALF;

  logic [2:0]                       st_r;
  logic [kwm_pkg::LEN_W-1:0]        len_r [LN];
  logic [LN-1:0]                    comp_r, exh_r, cand_r;
  logic                             fin_r, err_r;
  logic [3:0]                       p_r;
  logic [kwm_pkg::LEN_W-1:0]        e_r;
  logic [kwm_pkg::LANE_W-1:0]       best_r;
  logic [7:0]                       min_lo_r, min_hi_r;
  logic                             out_valid_r;
  kwm_pkg::out_res_t                out_r;

  logic [7:0]                       rd_q [LN];
  logic [3:0]                       raddr;
  logic                             wr_en;
  logic [kwm_pkg::LANE_W-1:0]       wr_lane;
  logic [kwm_pkg::LEN_W-1:0]        wr_addr;
  logic                             slot_free;
  logic                             out_load;

  kwm_pkg::in_req_t                 req;
  logic [LN-1:0]                    ended, eqm, nmask;
  logic [7:0]                       lo_c, hi_c, mn;

  assign req       = q_head.req;
  assign slot_free = !out_valid_r || !out_stall;
  assign out_load  = slot_free && ((st_r == S_EMWR) || (st_r == S_STAT));
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign q_pop     = (st_r == S_IDLE) && q_valid;
  assign raddr     = (st_r == S_EMRD || st_r == S_EMWR) ? e_r : p_r;
  assign wr_lane   = req.lane;
  assign wr_addr   = len_r[req.lane];
  assign wr_en     = q_pop && !q_head.bad && !comp_r[req.lane] && !exh_r[req.lane]
                     && (req.func != kwm_pkg::FUNC_EXH)
                     && (len_r[req.lane] < kwm_pkg::LEN_W'(kwm_pkg::MAX_WORD_LEN));

  for (genvar g = 0; g < LN; g++) begin : g_lane
    kwm_ram #(.WIDTH(8), .DEPTH(kwm_pkg::RAM_DEPTH)) u_ram (
      .clk   (clk),
      .we    (wr_en && (wr_lane == kwm_pkg::LANE_W'(g))),
      .waddr (wr_addr),
      .wdata (req.char_code),
      .raddr (raddr),
      .rdata (rd_q[g])
    );
  end

  always_comb begin
    lo_c = 8'hff;
    hi_c = 8'hff;
    for (int i = 0; i < HF; i++) begin
      if (cand_r[i] && rd_q[i] < lo_c) lo_c = rd_q[i];
    end
    for (int i = HF; i < LN; i++) begin
      if (cand_r[i] && rd_q[i] < hi_c) hi_c = rd_q[i];
    end
    mn = (min_lo_r <= min_hi_r) ? min_lo_r : min_hi_r;
    for (int i = 0; i < LN; i++) begin
      ended[i] = cand_r[i] && (len_r[i] <= p_r);
      eqm[i]   = (rd_q[i] == mn);
    end
    nmask = cand_r & eqm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      comp_r      <= '0;
      exh_r       <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LN; i++) len_r[i] <= '0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            st_r  <= S_CHECK;
            err_r <= q_head.bad || comp_r[req.lane] || exh_r[req.lane]
                     || ((req.func == kwm_pkg::FUNC_EXH) ? (len_r[req.lane] != '0)
                                                         : !wr_en);
            if (q_head.bad || comp_r[req.lane] || exh_r[req.lane]) begin
              // Rejected request: nothing changes.
            end else if (req.func == kwm_pkg::FUNC_EXH) begin
              if (len_r[req.lane] == '0) exh_r[req.lane] <= 1'b1;
            end else begin
              if (wr_en) len_r[req.lane] <= len_r[req.lane] + 1'b1;
              if (req.func == kwm_pkg::FUNC_LAST) comp_r[req.lane] <= 1'b1;
            end
          end
        end
        S_CHECK: begin
          if (!fin_r && ((comp_r | exh_r) == kwm_pkg::ALL_LANES) && (comp_r != '0)) begin
            p_r    <= key_offset;
            cand_r <= comp_r;
            st_r   <= S_RD;
          end else if (!fin_r && (exh_r == kwm_pkg::ALL_LANES)) begin
            fin_r <= 1'b1;
            st_r  <= S_STAT;
          end else if (err_r) begin
            st_r <= S_STAT;
          end else begin
            st_r <= S_IDLE;
          end
        end
        S_RD: st_r <= S_MIN;
        S_MIN: begin
          if (ended != '0) begin
            best_r <= kwm_pkg::lowest_lane(ended);
            e_r    <= '0;
            st_r   <= S_EMRD;
          end else begin
            min_lo_r <= lo_c;
            min_hi_r <= hi_c;
            st_r     <= S_FLT;
          end
        end
        S_FLT: begin
          if ((nmask & (nmask - 1'b1)) == '0) begin
            best_r <= kwm_pkg::lowest_lane(nmask);
            e_r    <= '0;
            st_r   <= S_EMRD;
          end else begin
            cand_r <= nmask;
            p_r    <= p_r + 4'd1;
            st_r   <= S_RD;
          end
        end
        S_EMRD: st_r <= S_EMWR;
        S_EMWR: begin
          if (slot_free) begin
            out_r.out_lane  <= best_r;
            out_r.out_char  <= rd_q[best_r];
            out_r.word_last <= (e_r == len_r[best_r] - 1'b1);
            out_r.all_done  <= fin_r;
            out_r.error     <= err_r;
            if (e_r == len_r[best_r] - 1'b1) begin
              len_r[best_r]  <= '0;
              comp_r[best_r] <= 1'b0;
              st_r           <= S_IDLE;
            end else begin
              e_r  <= e_r + 1'b1;
              st_r <= S_EMRD;
            end
          end
        end
        S_STAT: begin
          if (slot_free) begin
            out_r.out_lane  <= '0;
            out_r.out_char  <= '0;
            out_r.word_last <= 1'b0;
            out_r.all_done  <= fin_r;
            out_r.error     <= err_r;
            st_r            <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/k_way_word_merge_core.sv =====
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  kwm_pkg::in_req_t (func, lane, char_code)
// out_      output     out_valid/out_stall  kwm_pkg::out_res_t (lane, char, last, done, error)
// config    input      psel/penable/pwrite  key_offset at byte address 0
//
// In the back end an item passes through S_IDLE and S_CHECK when it emits nothing, and
// then through S_STAT with a status result. When a word is selected, each compared
// character position passes a lane memory read, a split minimum and a filter, and each
// emitted character a registered read of the winning lane memory and an output load.
// Reset is synchronous and active low; it clears lengths, flags and queues.
// The two-entry front queue takes requests until full while the back end waits on out_stall.
module k_way_word_merge_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kwm_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output kwm_pkg::out_res_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // The only register is the comparison start position.
  logic [3:0] key_offset_r;

  logic              q_valid;
  logic              q_pop;
  kwm_pkg::q_entry_t q_head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {28'd0, key_offset_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_offset_r <= 4'd2;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      key_offset_r <= pwdata[3:0];
    end
  end

  // The front end accepts requests and flags malformed ones.
  kwm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  // The back end holds the head words, selects the least and streams it out.
  kwm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_offset (key_offset_r),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== tb/sv/tb_k_way_word_merge_core.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the k-way word merge core.
// Requests are generated and scored by an in-bench merge predictor at the moment
// they are queued. Requests reach the core in queue order, so the expected
// character stream is known up front and the monitor only has to pop it.
module tb_k_way_word_merge_core;
  import kwm_pkg::*;

  localparam logic [2:0] ADDR_KEYOFF = 3'd0;
  // Lanes below this bound carry live words, and the rest are closed early.
  localparam int LIVE        = 5;
  localparam int DRAIN_WAIT  = 200;
  localparam int STALL_LIMIT = 20000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_stall;
  out_res_t out_data;
  logic     psel;
  logic     penable;
  logic     pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  k_way_word_merge_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Shadow copy of the merge state. The predictor updates it, and set_key_offset sets key_pos.
  logic [7:0]       word_buf [LANES][MAX_WORD_LEN];
  int               word_len [LANES];
  logic [LANES-1:0] ready_mask;
  logic [LANES-1:0] closed_mask;
  bit               merge_over;
  int               key_pos;

  // Generator bookkeeping for well-formed words on the live lanes.
  int sent_chars [LIVE];
  int target_len [LIVE];

  in_req_t  pending_reqs [$];
  out_res_t merged_chars [$];

  int  fail_count;
  int  mismatch_count;
  int  req_count;
  int  words_out;
  int  err_results;
  bit  quiet;
  bit  in_taken;
  int  in_gap;
  int  out_gap;
  int  idle_cycles;

  // True if the head of lane a sorts strictly ahead of the head of lane b.
  function automatic bit head_precedes(int a, int b);
    int i;
    int sa;
    int sb;
    i = key_pos;
    while (i < word_len[a] && i < word_len[b]) begin
      if (word_buf[a][i] != word_buf[b][i]) return word_buf[a][i] < word_buf[b][i];
      i++;
    end
    sa = word_len[a] > key_pos ? word_len[a] - key_pos : 0;
    sb = word_len[b] > key_pos ? word_len[b] - key_pos : 0;
    return sa < sb;
  endfunction

  // Applies one request to the shadow state and appends the characters it releases.
  function automatic void merge_request(in_req_t r);
    bit err;
    bit newly_over;
    int best;
    int l;
    out_res_t res;
    err = 1'b0;
    newly_over = 1'b0;
    best = -1;
    l = int'(r.lane);
    if (l >= LANES || r.func == FUNC_UNDEF) begin
      err = 1'b1;
    end else if (closed_mask[l] || ready_mask[l]) begin
      err = 1'b1;
    end else if (r.func == FUNC_EXH) begin
      // A lane can only be closed between words.
      if (word_len[l] != 0) err = 1'b1;
      else closed_mask[l] = 1'b1;
    end else begin
      // An overlong character is dropped, but a last character still seals the word.
      if (word_len[l] < MAX_WORD_LEN) begin
        word_buf[l][word_len[l]] = r.char_code;
        word_len[l]++;
      end else begin
        err = 1'b1;
      end
      if (r.func == FUNC_LAST) ready_mask[l] = 1'b1;
    end

    if (!merge_over && (ready_mask | closed_mask) == ALL_LANES && ready_mask != '0) begin
      for (int i = 0; i < LANES; i++) begin
        if (ready_mask[i] && (best < 0 || head_precedes(i, best))) best = i;
      end
      for (int i = 0; i < word_len[best]; i++) begin
        res = '{out_lane: 4'(best), out_char: word_buf[best][i],
                word_last: (i + 1 == word_len[best]), all_done: merge_over, error: err};
        merged_chars = {merged_chars, res};
      end
      word_len[best] = 0;
      ready_mask[best] = 1'b0;
      words_out++;
    end else if (!merge_over && closed_mask == ALL_LANES) begin
      merge_over = 1'b1;
      newly_over = 1'b1;
    end

    // Without an emitted word, a status result still reports errors and the finish.
    if (best < 0 && (err || newly_over)) begin
      res = '{out_lane: '0, out_char: '0, word_last: 1'b0, all_done: merge_over, error: err};
      merged_chars = {merged_chars, res};
    end
    if (err) err_results++;
  endfunction

  task automatic send(logic [1:0] f, int l, logic [7:0] c);
    in_req_t r;
    r = '{func: f, lane: 4'(l), char_code: c};
    merge_request(r);
    pending_reqs = {pending_reqs, r};
    req_count++;
  endtask

  // Mostly interleaved well-formed words on the live lanes; about one request in
  // ten is noise that may hit a full, closed or nonexistent lane.
  task automatic random_words(int n);
    int l;
    logic [7:0] c;
    logic [1:0] f;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        f = 2'($urandom_range(0, 3));
        l = $urandom_range(0, 15);
        // Never close a live lane here, or the merge would end too early.
        if (f == FUNC_EXH && l < LIVE) l = l + 8;
        send(f, l, 8'($urandom_range(0, 255)));
      end else begin
        l = $urandom_range(0, LIVE - 1);
        while (ready_mask[l]) l = (l + 1) % LIVE;
        if (sent_chars[l] == 0) begin
          target_len[l] = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 17)
                                                        : $urandom_range(1, 6);
        end
        // A small alphabet makes ties and shared prefixes common.
        c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(97, 100));
        sent_chars[l]++;
        if (sent_chars[l] >= target_len[l]) begin
          send(FUNC_LAST, l, c);
          sent_chars[l] = 0;
        end else begin
          send(FUNC_CHAR, l, c);
        end
      end
    end
  endtask

  // Waits for the core to settle, then lets trailing work finish.
  task automatic drain();
    while (pending_reqs.size() != 0 || merged_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Writes key_offset through the two-phase register port and reads it back.
  task automatic set_key_offset(int v);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_KEYOFF;
    pwdata <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[3:0] != 4'(v)) begin
      $error("key_offset readback: expected %0d, actual %0d", v, prdata[3:0]);
      fail_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    key_pos = v;
  endtask

  // Input driver. The request stays put until it is accepted, and idle gaps only
  // begin once nothing is being offered.
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
  end

  always @(negedge clk) begin
    logic     v;
    in_req_t  d;
    v = 1'b0;
    d = '0;
    if (!rst_n) begin
      in_gap = 0;
    end else begin
      d = in_data;
      if (in_valid && !in_taken) begin
        v = 1'b1;
      end else begin
        if (in_valid && in_taken) void'(pending_reqs.pop_front());
        if (in_gap == 0 && !quiet && $urandom_range(0, 11) == 0) in_gap = $urandom_range(1, 17);
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_reqs.size() != 0) begin
          v = 1'b1;
          d = pending_reqs[0];
        end
      end
    end
    in_valid <= v;
    in_data <= d;
  end

  // Result side back-pressure in bursts.
  always @(negedge clk) begin
    logic s;
    s = 1'b0;
    if (!rst_n) begin
      out_gap = 0;
    end else if (!quiet) begin
      if (out_gap == 0 && $urandom_range(0, 9) == 0) out_gap = $urandom_range(1, 17);
      if (out_gap > 0) begin
        s = 1'b1;
        out_gap--;
      end
    end
    out_stall <= s;
  end

  // Scoreboard. Every accepted result must match the oldest expected one.
  always @(posedge clk) begin
    out_res_t e;
    if (!rst_n) begin
      mismatch_count = 0;
    end else if (out_valid && !out_stall) begin
      if (merged_chars.size() == 0) begin
        $error("unexpected result: lane %0d char %0d", out_data.out_lane, out_data.out_char);
        mismatch_count++;
      end else begin
        e = merged_chars.pop_front();
        if (out_data.out_lane !== e.out_lane) begin
          $error("out_lane: expected %0d, actual %0d", e.out_lane, out_data.out_lane);
          mismatch_count++;
        end
        if (out_data.out_char !== e.out_char) begin
          $error("out_char: expected %0d, actual %0d", e.out_char, out_data.out_char);
          mismatch_count++;
        end
        if (out_data.word_last !== e.word_last) begin
          $error("word_last: expected %0d, actual %0d", e.word_last, out_data.word_last);
          mismatch_count++;
        end
        if (out_data.all_done !== e.all_done) begin
          $error("all_done: expected %0d, actual %0d", e.all_done, out_data.all_done);
          mismatch_count++;
        end
        if (out_data.error !== e.error) begin
          $error("error: expected %0d, actual %0d", e.error, out_data.error);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer on any port.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("k_way_word_merge_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    quiet = 1'b0;
    fail_count = 0;
    req_count = 0;
    words_out = 0;
    err_results = 0;
    ready_mask = '0;
    closed_mask = '0;
    merge_over = 1'b0;
    key_pos = 2;
    for (int i = 0; i < LANES; i++) word_len[i] = 0;
    for (int i = 0; i < LIVE; i++) begin
      sent_chars[i] = 0;
      target_len[i] = 1;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, at the reset key offset. Lanes with no words at all are closed
    // first, which must end them cleanly without blocking the merge.
    for (int l = LIVE; l < LANES; l++) send(FUNC_EXH, l, 8'hff);
    send(FUNC_UNDEF, 0, 8'h41);          // undefined func
    send(FUNC_CHAR, 15, 8'h00);          // lane out of range
    send(FUNC_CHAR, 7, 8'h61);           // closed lane
    send(FUNC_CHAR, 0, 8'h78);
    send(FUNC_EXH, 0, 8'h00);            // close attempt on a partial word
    send(FUNC_LAST, 0, 8'hff);
    send(FUNC_CHAR, 0, 8'h62);           // lane already holds a full word
    send(FUNC_LAST, 1, 8'h00);           // one-character word, shorter than the key offset
    send(FUNC_CHAR, 2, 8'h61);
    send(FUNC_CHAR, 2, 8'h62);
    send(FUNC_LAST, 2, 8'h63);
    send(FUNC_CHAR, 3, 8'h61);
    send(FUNC_CHAR, 3, 8'h62);
    send(FUNC_LAST, 3, 8'h63);           // tie with lane 2 goes to the lower lane
    send(FUNC_CHAR, 4, 8'h7a);
    send(FUNC_CHAR, 4, 8'h7a);
    send(FUNC_LAST, 4, 8'h63);
    random_words(35);
    drain();

    // Each later phase sweeps a different key offset, the extremes included.
    set_key_offset(0);
    random_words(35);
    drain();
    set_key_offset(14);
    random_words(30);
    drain();
    set_key_offset(7);
    random_words(25);
    drain();
    set_key_offset(1);
    quiet = 1'b1;
    random_words(25);

    // Close out: seal partial words, close empty live lanes, and nudge the merge
    // with requests to a closed lane until every lane is done.
    for (int l = 0; l < LIVE; l++) begin
      if (!ready_mask[l] && word_len[l] != 0) send(FUNC_LAST, l, 8'h7e);
    end
    while (!merge_over) begin
      int pick;
      pick = -1;
      for (int l = 0; l < LIVE; l++) begin
        if (pick < 0 && !closed_mask[l] && !ready_mask[l] && word_len[l] == 0) pick = l;
      end
      if (pick >= 0) send(FUNC_EXH, pick, 8'h00);
      else send(FUNC_CHAR, 12, 8'h55);
    end
    send(FUNC_LAST, 0, 8'h61);           // everything errs after the finish
    send(FUNC_EXH, 3, 8'h00);
    drain();

    if (merged_chars.size() != 0) begin
      $error("%0d expected results never arrived", merged_chars.size());
      fail_count++;
    end
    $display("Merged %0d words from %0d requests over five key offsets;", words_out, req_count);
    $display("%0d requests were flagged as misuse.", err_results);
    if (fail_count == 0 && mismatch_count == 0) begin
      $display("k_way_word_merge_core regression: pass");
    end else begin
      $display("k_way_word_merge_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/kwm_pkg.sv
design/kwm_ram.sv
design/kwm_front.sv
design/kwm_back.sv
design/k_way_word_merge_core.sv
tb/sv/tb_k_way_word_merge_core.sv
